// ===== hdl/ggvc_pkg.sv =====
// shared types, constants and the arctangent table for the go-to-goal controller
package ggvc_pkg;

  localparam int XY_W       = 28;   // cordic x/y datapath, Q.19 plus growth
  localparam int Z_W        = 24;   // cordic angle accumulator, Q.20
  localparam int ERR_W      = 25;   // heading error, Q.20
  localparam int DIST_W     = 20;   // distance, Q.11
  localparam int MAX_STAGES = 24;

  localparam logic signed [ERR_W-1:0] ANG_PI     = 25'sd3294199;
  localparam logic signed [ERR_W-1:0] ANG_TWO_PI = 25'sd6588398;
  localparam logic [19:0]             INV_GAIN   = 20'd636751;

  localparam logic [1:0] REG_GOAL_X    = 2'd0;
  localparam logic [1:0] REG_GOAL_Y    = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  localparam logic signed [15:0] GOAL_X_RST    = 16'sd11355;
  localparam logic signed [15:0] GOAL_Y_RST    = 16'sd11355;
  localparam logic [14:0]        TOLERANCE_RST = 15'd205;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [15:0]     hd;
  } ggvc_vec_t;

  typedef struct packed {
    logic               arrived;
    logic signed [14:0] angular_velocity;
    logic [14:0]        linear_velocity;
  } ggvc_result_t;

  // atan(2^-i) in Q.20
  function automatic logic signed [Z_W-1:0] cordic_atan(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 24'sd823550;
      1:  a = 24'sd486170;
      2:  a = 24'sd256879;
      3:  a = 24'sd130396;
      4:  a = 24'sd65451;
      5:  a = 24'sd32757;
      6:  a = 24'sd16383;
      7:  a = 24'sd8192;
      8:  a = 24'sd4096;
      9:  a = 24'sd2048;
      10: a = 24'sd1024;
      11: a = 24'sd512;
      12: a = 24'sd256;
      13: a = 24'sd128;
      14: a = 24'sd64;
      15: a = 24'sd32;
      16: a = 24'sd16;
      17: a = 24'sd8;
      18: a = 24'sd4;
      19: a = 24'sd2;
      20: a = 24'sd1;
      21: a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/goto_goal_velocity_controller_core.sv =====
// top level of the proportional go-to-goal velocity controller
//
// Each pose item (x, y, heading) on the in_ stream gives exactly one velocity
// command on the out_ stream, in order. The bearing and distance to the goal
// come from a pipelined cordic vectoring unit, one micro-rotation per stage;
// the heading error is wrapped once into plus or minus pi, the turn command is
// half of it clamped to plus or minus 0.5 (Q1.14) and the forward command is
// half the distance clamped to 1.0, both forced to zero with arrived set when
// the distance is at or below arrive_tolerance. A new item is taken every
// clock while in_tready is high; from acceptance to out_tvalid an item passes
// two offset/fold stages, the cordic stages, three stages of gain multiply,
// wrap/round and clamp, and the output register. The whole pipeline moves
// together and holds when the output skid entry is occupied, so in_tready is
// a flop and drops in the cycle after the consumer has stalled on a shown item
// while another one was arriving. The user writes the goal and tolerance
// registers through cfg_ only while no item is in flight; the block does not
// enforce this, and writes to unused indexes are ignored.
module goto_goal_velocity_controller_core
  import ggvc_pkg::*;
#(
  parameter int CORDIC_STAGES = 14   // 8 to 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // pose items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pose_x[15:0], pose_y[31:16], pose_heading[47:32]
  // velocity commands
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // linear_velocity[14:0], angular_velocity[29:15],
                                  // arrived[30], zero[31]
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic signed [15:0] goal_x_r, goal_y_r;
  logic [14:0]        tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= GOAL_X_RST;
      goal_y_r <= GOAL_Y_RST;
      tol_r    <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GOAL_X:    goal_x_r <= cfg_wdata;
        REG_GOAL_Y:    goal_y_r <= cfg_wdata;
        REG_TOLERANCE: tol_r    <= cfg_wdata[14:0];
        default:       ;
      endcase
    end
  end

  // global pipeline advance: stalls only while the skid entry is full
  logic         en;
  logic         prep_valid, cordic_valid, post_valid;
  ggvc_vec_t    prep_vec, cordic_vec;
  ggvc_result_t post_res, out_res;

  assign in_tready = en;

  ggvc_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .pose_x       (in_tdata[15:0]),
    .pose_y       (in_tdata[31:16]),
    .pose_heading (in_tdata[47:32]),
    .goal_x       (goal_x_r),
    .goal_y       (goal_y_r),
    .vec_valid    (prep_valid),
    .vec          (prep_vec)
  );

  ggvc_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_valid),
    .in_vec    (prep_vec),
    .out_valid (cordic_valid),
    .out_vec   (cordic_vec)
  );

  ggvc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cordic_valid),
    .in_vec    (cordic_vec),
    .tolerance (tol_r),
    .res_valid (post_valid),
    .res       (post_res)
  );

  ggvc_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (post_valid),
    .up_data  (post_res),
    .up_ready (en),
    .dn_valid (out_tvalid),
    .dn_data  (out_res),
    .dn_ready (out_tready)
  );

  assign out_tdata = {1'b0, out_res.arrived, out_res.angular_velocity,
                      out_res.linear_velocity};

  // arrival forces both commands to zero
  a_arrived_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.arrived) |->
      (out_res.linear_velocity == '0 && out_res.angular_velocity == '0))
    else $error("arrived item carries nonzero command");

  // forward command saturates at 1.0
  a_lin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.linear_velocity <= 15'd16384))
    else $error("linear command above saturation");

  // turn command stays within plus or minus 0.5
  a_ang_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.angular_velocity <= 15'sd8192 &&
                    out_res.angular_velocity >= -15'sd8192))
    else $error("angular command outside saturation");

  // input side closes only after the output has been stalled
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> ($past(out_tvalid) && !$past(out_tready)))
    else $error("in_tready dropped without an output stall");

endmodule

// ===== hdl/ggvc_prep.sv =====
// offset to goal and half-plane fold ahead of the cordic pipeline
module ggvc_prep
  import ggvc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  logic signed [15:0] goal_x,
  input  logic signed [15:0] goal_y,
  output logic               vec_valid,
  output ggvc_vec_t          vec
);

  logic               s1_valid_r;
  logic signed [16:0] dx_r, dy_r;
  logic signed [15:0] hd_r;
  logic signed [16:0] dx_nxt, dy_nxt;
  logic signed [16:0] fx, fy;
  logic signed [Z_W-1:0] z0;
  ggvc_vec_t          vec_r, vec_nxt;
  logic               vec_valid_r;

  assign dx_nxt = {goal_x[15], goal_x} - {pose_x[15], pose_x};
  assign dy_nxt = {goal_y[15], goal_y} - {pose_y[15], pose_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      hd_r <= pose_heading;
    end
  end

  // left half-plane: rotate by pi and preset the angle
  always_comb begin
    if (dx_r < 0) begin
      fx = -dx_r;
      fy = -dy_r;
      z0 = (dy_r >= 0) ? ANG_PI[Z_W-1:0] : -ANG_PI[Z_W-1:0];
    end else begin
      fx = dx_r;
      fy = dy_r;
      z0 = '0;
    end
    vec_nxt.x  = {{(XY_W-25){fx[16]}}, fx, 8'b0};
    vec_nxt.y  = {{(XY_W-25){fy[16]}}, fy, 8'b0};
    vec_nxt.z  = z0;
    vec_nxt.hd = hd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_valid_r <= 1'b0;
    end else if (en) begin
      vec_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_valid = vec_valid_r;
  assign vec       = vec_r;

endmodule

// ===== hdl/ggvc_cordic.sv =====
// pipelined cordic vectoring, one micro-rotation per register stage
module ggvc_cordic
  import ggvc_pkg::*;
#(
  parameter int CORDIC_STAGES = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  ggvc_vec_t in_vec,
  output logic      out_valid,
  output ggvc_vec_t out_vec
);

  logic      vld_r [CORDIC_STAGES];
  ggvc_vec_t vec_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN_I = cordic_atan(i);
    ggvc_vec_t              src, dst;
    logic                   src_v;
    logic signed [XY_W-1:0] sx, sy, xs, ys;

    if (i == 0) begin : g_first
      assign src   = in_vec;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = vec_r[i-1];
      assign src_v = vld_r[i-1];
    end

    assign sx = src.x;
    assign sy = src.y;
    assign xs = sx >>> i;
    assign ys = sy >>> i;

    always_comb begin
      dst.hd = src.hd;
      if (sy >= 0) begin
        dst.x = sx + ys;
        dst.y = sy - xs;
        dst.z = src.z + ATAN_I;
      end else begin
        dst.x = sx - ys;
        dst.y = sy + xs;
        dst.z = src.z - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec_r[i] <= dst;
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STAGES-1];
  assign out_vec   = vec_r[CORDIC_STAGES-1];

endmodule

// ===== hdl/ggvc_post.sv =====
// gain removal, heading error wrap and command shaping
module ggvc_post
  import ggvc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  ggvc_vec_t    in_vec,
  input  logic [14:0]  tolerance,
  output logic         res_valid,
  output ggvc_result_t res
);

  // stage 1: gain multiply and raw error
  logic                    p1_valid_r;
  logic [46:0]             prod_r, prod_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [26:0]             xu;

  assign xu       = in_vec.x[XY_W-1] ? '0 : in_vec.x[26:0];
  assign prod_nxt = 47'(xu) * 47'(INV_GAIN);
  assign err_nxt  = {in_vec.z[Z_W-1], in_vec.z} - {{2{in_vec.hd[15]}}, in_vec.hd, 7'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      err_r  <= err_nxt;
    end
  end

  // stage 2: round distance, wrap error once
  logic                    p2_valid_r;
  logic [DIST_W-1:0]       dist_r, dist_nxt;
  logic signed [ERR_W-1:0] werr_r, werr_nxt;
  logic [47:0]             rsum;

  assign rsum     = {1'b0, prod_r} + (48'd1 << 27);
  assign dist_nxt = rsum[47:28];

  always_comb begin
    if (err_r > ANG_PI) begin
      werr_nxt = err_r - ANG_TWO_PI;
    end else if (err_r < -ANG_PI) begin
      werr_nxt = err_r + ANG_TWO_PI;
    end else begin
      werr_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      werr_r <= werr_nxt;
    end
  end

  // stage 3: clamp both commands, stop inside tolerance
  logic                    p3_valid_r;
  ggvc_result_t            res_r, res_nxt;
  logic signed [ERR_W-1:0] ang_full;
  logic signed [14:0]      ang_sat;
  logic [14:0]             lin_sat;

  assign ang_full = (werr_r + 25'sd64) >>> 7;

  always_comb begin
    if (ang_full > 25'sd8192) begin
      ang_sat = 15'sd8192;
    end else if (ang_full < -25'sd8192) begin
      ang_sat = -15'sd8192;
    end else begin
      ang_sat = ang_full[14:0];
    end
    if (dist_r >= DIST_W'(4096)) begin
      lin_sat = 15'd16384;
    end else begin
      lin_sat = {1'b0, dist_r[11:0], 2'b00};
    end
    if (dist_r > {{(DIST_W-15){1'b0}}, tolerance}) begin
      res_nxt.arrived          = 1'b0;
      res_nxt.angular_velocity = ang_sat;
      res_nxt.linear_velocity  = lin_sat;
    end else begin
      res_nxt.arrived          = 1'b1;
      res_nxt.angular_velocity = '0;
      res_nxt.linear_velocity  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (en) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = p3_valid_r;
  assign res       = res_r;

endmodule

// ===== hdl/ggvc_outbuf.sv =====
// output register with a skid entry so upstream ready is a flop
module ggvc_outbuf
  import ggvc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  input  ggvc_result_t up_data,
  output logic         up_ready,
  output logic         dn_valid,
  output ggvc_result_t dn_data,
  input  logic         dn_ready
);

  logic         out_valid_r, skid_valid_r;
  ggvc_result_t out_data_r, skid_data_r;
  logic         up_fire, out_free;

  assign up_ready = ~skid_valid_r;
  assign up_fire  = up_valid & ~skid_valid_r;
  assign out_free = dn_ready | ~out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= up_fire;
        end
      end else if (up_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : up_data;
    end
    if (!out_free && up_fire) begin
      skid_data_r <= up_data;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_data  = out_data_r;

  // a waiting skid entry always sits behind a shown item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

endmodule
